// ===== design/fsta_pkg.sv =====
`default_nettype none
package fsta_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned CornerW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // triangle queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [CornerW-1:0] CORNER_FIRST = 2'd0;
  localparam logic [CornerW-1:0] CORNER_MID   = 2'd1;
  localparam logic [CornerW-1:0] CORNER_LAST  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_MODE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLOR = 2'd1;

  localparam logic MODE_FAN   = 1'b0;
  localparam logic MODE_STRIP = 1'b1;

  localparam logic [ColorW-1:0] COLOR_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic [CoordW-1:0] vertex_x;
    logic [CoordW-1:0] vertex_y;
    logic              ends_polygon;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0]  out_x;
    logic [CoordW-1:0]  out_y;
    logic [ColorW-1:0]  out_color;
    logic [CornerW-1:0] corner_index;
    logic               triangle_done;
  } out_item_t;

  typedef struct packed {
    vertex_t           c0;
    vertex_t           c1;
    vertex_t           c2;
    logic [ColorW-1:0] color;
  } tri_t;

  // one side of a queue port: request plus triangle
  typedef struct packed {
    logic valid;
    tri_t data;
  } tri_xfer_t;

endpackage
`default_nettype wire

// ===== design/fsta_front.sv =====
`default_nettype none
module fsta_front import fsta_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_item_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                q_full_i,
  output tri_xfer_t                push_o
);

  logic              mode_q;
  logic [ColorW-1:0] color_q;
  vertex_t           anchor_q, anchor_d;
  vertex_t           older_q, newer_q;
  logic [1:0]        seen_q, seen_d;
  logic              parity_q, parity_d;
  vertex_t           cur;
  logic              accept;
  logic              emit;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cur         = '{y: in_item_i.vertex_y, x: in_item_i.vertex_x};
  assign emit        = (seen_q == 2'd2);
  assign anchor_d    = (seen_q == 2'd0) ? cur : anchor_q;

  always_comb begin
    if (in_item_i.ends_polygon) begin
      seen_d   = 2'd0;
      parity_d = 1'b0;
    end else begin
      seen_d   = (seen_q == 2'd2) ? seen_q : seen_q + 2'd1;
      parity_d = !parity_q;
    end
  end

  // triangle corner order per mode and winding
  always_comb begin
    push_o.valid      = accept && emit;
    push_o.data.color = color_q;
    if (mode_q == MODE_FAN) begin
      push_o.data.c0 = anchor_q;
      push_o.data.c1 = newer_q;
      push_o.data.c2 = cur;
    end else if (!parity_q) begin
      push_o.data.c0 = cur;
      push_o.data.c1 = older_q;
      push_o.data.c2 = newer_q;
    end else begin
      push_o.data.c0 = cur;
      push_o.data.c1 = newer_q;
      push_o.data.c2 = older_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_FAN;
      color_q  <= COLOR_RESET;
      seen_q   <= 2'd0;
      parity_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MODE:  mode_q  <= cfg_data_i[0];
          CFG_COLOR: color_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        seen_q   <= seen_d;
        parity_q <= parity_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      anchor_q <= anchor_d;
      older_q  <= newer_q;
      newer_q  <= cur;
    end
  end

endmodule
`default_nettype wire

// ===== design/fsta_queue.sv =====
`default_nettype none
module fsta_queue import fsta_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tri_xfer_t push_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output tri_xfer_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  tri_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o      = (count_q == CntFull);
  assign head_o.valid = (count_q != '0);
  assign head_o.data  = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule
`default_nettype wire

// ===== design/fsta_back.sv =====
`default_nettype none
module fsta_back import fsta_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tri_xfer_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  tri_t               tri_q;
  logic               busy_q;
  logic [CornerW-1:0] corner_q;
  logic               out_fire;
  logic               tri_end;
  vertex_t            sel;

  assign out_valid_o = busy_q;
  assign out_fire    = busy_q && out_ready_i;
  assign tri_end     = out_fire && (corner_q == CORNER_LAST);
  assign pop_o       = head_i.valid && (!busy_q || tri_end);

  always_comb begin
    unique case (corner_q)
      CORNER_FIRST: sel = tri_q.c0;
      CORNER_MID:   sel = tri_q.c1;
      default:      sel = tri_q.c2;
    endcase
  end

  assign out_item_o.out_x         = sel.x;
  assign out_item_o.out_y         = sel.y;
  assign out_item_o.out_color     = tri_q.color;
  assign out_item_o.corner_index  = corner_q;
  assign out_item_o.triangle_done = (corner_q == CORNER_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      corner_q <= CORNER_FIRST;
    end else begin
      if (pop_o) begin
        busy_q   <= 1'b1;
        corner_q <= CORNER_FIRST;
      end else if (tri_end) begin
        busy_q   <= 1'b0;
        corner_q <= CORNER_FIRST;
      end else if (out_fire) begin
        corner_q <= corner_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tri_q <= head_i.data;
    end
  end

endmodule
`default_nettype wire

// ===== design/fan_strip_triangle_assembly.sv =====
// Path: a vertex that completes a triangle is queued; the back then loads and shows it.
// Throughput: vertices enter one per cycle while the triangle queue has room; each
//   triangle leaves as 3 items, one per cycle while out_ready_i is high, so the
//   single-item output port sets the sustained rate of triangle-producing vertices.
// Reset: polygon counters, queue and output clear; mode resets to fan, color to all ones.
`default_nettype none
module fan_strip_triangle_assembly import fsta_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // vertex input
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_item_i,
  // triangle corner output
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_item_t                out_item_o,
  // register writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Front: tracks anchor and last two vertices per polygon, orders the
  // corners for fan or strip and pushes a whole triangle at once.
  tri_xfer_t push;
  tri_xfer_t head;
  logic      q_full;
  logic      pop;

  fsta_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  // Triangle queue lets the front keep taking vertices while corners drain.
  fsta_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  // Back: holds one triangle and hands out its three corners in order;
  // the next triangle loads on the same edge the last corner is taken.
  fsta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire
